// ===== rtl/core/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants for the step pattern player
// Opcodes, status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam logic [2:0] OP_HEADER  = 3'd0;
    localparam logic [2:0] OP_PATTERN = 3'd1;
    localparam logic [2:0] OP_COMMIT  = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_START   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    localparam logic [20:0] BASE_CLOCK  = 21'd1600000;
    localparam logic [16:0] SEARCH_LIM  = 17'd65536;
    localparam logic [15:0] COMPARE_CAP = 16'd65535;
    localparam logic [7:0]  PIN_MASK    = 8'hFC;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch input item
        logic read;       // read stores at head
        logic exec;       // apply the item
        logic div_start;  // load divider for next prescaler
        logic div_step;   // one quotient bit
        logic out_load;   // load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_last;   // divider on its last bit
        logic need_div;   // item started a message
        logic search_done;// prescaler search finished
    } sts_t;

    // prescaler shift: divide 1,8,64,256,1024 for codes 1..5
    function automatic logic [3:0] pre_shift(input logic [2:0] sel);
        logic [3:0] s;
        begin
            s = 4'd0;
            case (sel)
                3'd2: s = 4'd3;
                3'd3: s = 4'd6;
                3'd4: s = 4'd8;
                3'd5: s = 4'd10;
                default: s = 4'd0;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/core/spp_if.sv =====
// ----------------------------------------------------------------------------
// spp_in_if / spp_out_if: valid-ready channels of the step pattern player
// Input items carry opcode and message data; result items carry pin state.
// ----------------------------------------------------------------------------
interface spp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [14:0] rate_dekahertz;
    logic signed [15:0] repeat_count;
    logic [4:0]  pattern_count;
    logic [3:0]  pattern_index;
    logic [7:0]  pattern_value;
    modport source (output valid, opcode, rate_dekahertz, repeat_count,
                    pattern_count, pattern_index, pattern_value, input ready);
    modport sink (input valid, opcode, rate_dekahertz, repeat_count,
                  pattern_count, pattern_index, pattern_value, output ready);
endinterface

interface spp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pin_byte;
    logic        pin_valid;
    logic        running;
    logic        rate_valid;
    logic [15:0] compare_value;
    logic [2:0]  clock_select;
    logic [5:0]  queued;
    logic [1:0]  status;
    modport source (output valid, pin_byte, pin_valid, running, rate_valid,
                    compare_value, clock_select, queued, status, input ready);
    modport sink (input valid, pin_byte, pin_valid, running, rate_valid,
                  compare_value, clock_select, queued, status, output ready);
endinterface

// ===== rtl/core/spp_ctrl.sv =====
// ----------------------------------------------------------------------------
// spp_ctrl: sequencer of the step pattern player
// Walks each item through read, execute, the timer search if the item starts a message, and result load.
// ----------------------------------------------------------------------------
module spp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_busy,
    input  spp_pkg::sts_t  sts,
    output spp_pkg::cmd_t  cmd
);

    spp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            spp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = spp_pkg::S_READ;
                end
            end
            spp_pkg::S_READ:
            begin
                cmd.read = 1'b1;
                state_next = spp_pkg::S_EXEC;
            end
            spp_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = spp_pkg::S_OUT;
                if (sts.need_div)
                    state_next = spp_pkg::S_DIV;
            end
            spp_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    if (sts.search_done)
                        state_next = spp_pkg::S_OUT;
                    else
                        cmd.div_start = 1'b1;
                end
            end
            spp_pkg::S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = spp_pkg::S_IDLE;
                end
            end
            default: state_next = spp_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/spp_datapath.sv =====
// ----------------------------------------------------------------------------
// spp_datapath: queue stores, playback registers and timer divider
// Restoring divider forms 1600000 / (rate << shift), one bit a cycle.
// ----------------------------------------------------------------------------
module spp_datapath #(
    parameter int QUEUE_DEPTH  = 32,
    parameter int MAX_PATTERNS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  spp_pkg::cmd_t  cmd,
    output spp_pkg::sts_t  sts,
    input  logic [2:0]     opcode,
    input  logic [14:0]    rate_dekahertz,
    input  logic [15:0]    repeat_count,
    input  logic [4:0]     pattern_count,
    input  logic [3:0]     pattern_index,
    input  logic [7:0]     pattern_value,
    output logic [7:0]     pin_byte,
    output logic           pin_valid,
    output logic           running,
    output logic           rate_valid,
    output logic [15:0]    compare_value,
    output logic [2:0]     clock_select,
    output logic [5:0]     queued,
    output logic [1:0]     status
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PD = 1 << PW;   // pattern slots per message
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(MAX_PATTERNS + 1);
    localparam int DW = 21;   // dividend width
    localparam int VW = 26;   // divisor width: 15 + 10 + 1

    logic [35:0] hdr_mem [QUEUE_DEPTH];
    logic [5:0]  pat_mem [QUEUE_DEPTH * PD];

    logic [2:0]  op_reg;
    logic [14:0] rate_in_reg;
    logic [15:0] rep_in_reg;
    logic [4:0]  cnt_in_reg;
    logic [3:0]  idx_in_reg;
    logic [5:0]  val_in_reg;

    logic [QW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] cursor_reg;
    logic signed [15:0] passes_reg;
    logic          playing_reg;

    logic [35:0] hdr_rd_reg;
    logic [35:0] nxt_rd_reg;
    logic [5:0]  pat_rd_reg;

    logic [7:0]  pin_reg;
    logic        pinv_reg, ratev_reg;
    logic [1:0]  stat_reg;
    logic [14:0] rate_reg;
    logic [2:0]  sel_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [4:0]  bit_reg;

    logic full;
    logic [QW-1:0] head_inc, tail_inc;
    assign full = count_reg >= CW'(QUEUE_DEPTH);
    assign head_inc = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // pattern read address at head and cursor
    logic [PW-1:0] cur_idx;
    assign cur_idx = (cursor_reg < SW'(MAX_PATTERNS)) ? PW'(cursor_reg) : '0;

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !full && op_reg == spp_pkg::OP_HEADER)
            hdr_mem[tail_reg] <= {rate_in_reg, rep_in_reg, cnt_in_reg};
        if (cmd.exec && !full && op_reg == spp_pkg::OP_PATTERN
            && 32'(idx_in_reg) < MAX_PATTERNS)
            pat_mem[{tail_reg, PW'(idx_in_reg)}] <= val_in_reg;
        if (cmd.read)
        begin
            hdr_rd_reg <= hdr_mem[head_reg];
            nxt_rd_reg <= hdr_mem[head_inc];
            pat_rd_reg <= pat_mem[{head_reg, cur_idx}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            rate_in_reg <= rate_dekahertz;
            rep_in_reg  <= repeat_count;
            cnt_in_reg  <= pattern_count;
            idx_in_reg  <= pattern_index;
            val_in_reg  <= pattern_value[7:2];
        end
    end

    // row length of head
    logic [SW:0] len;
    assign len = (32'(hdr_rd_reg[4:0]) > MAX_PATTERNS) ? (SW+1)'(MAX_PATTERNS)
                                                       : (SW+1)'(hdr_rd_reg[4:0]);
    logic [SW:0] cur_inc;
    assign cur_inc = (SW+1)'(cur_idx) + 1'b1;
    logic wrap;
    assign wrap = cur_inc >= len;
    logic signed [15:0] pass_dec;
    assign pass_dec = (wrap && passes_reg != 16'sh8000) ? passes_reg - 16'sd1 : passes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            cursor_reg  <= '0;
            passes_reg  <= '0;
            playing_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            unique case (op_reg)
                spp_pkg::OP_COMMIT:
                    if (!full)
                    begin
                        tail_reg  <= tail_inc;
                        count_reg <= count_reg + 1'b1;
                    end
                spp_pkg::OP_TICK:
                    if (playing_reg && count_reg != '0)
                    begin
                        cursor_reg <= wrap ? '0 : SW'(cur_inc);
                        passes_reg <= pass_dec;
                        if (pass_dec <= 0)
                        begin
                            head_reg  <= head_inc;
                            count_reg <= count_reg - 1'b1;
                            if (count_reg != CW'(1))
                            begin
                                cursor_reg <= '0;
                                passes_reg <= nxt_rd_reg[20:5];
                            end
                            else
                            begin
                                playing_reg <= 1'b0;
                                cursor_reg  <= '0;
                            end
                        end
                    end
                spp_pkg::OP_START:
                    if (!playing_reg && count_reg != '0)
                    begin
                        cursor_reg  <= '0;
                        passes_reg  <= hdr_rd_reg[20:5];
                        playing_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    logic start_tick, start_go;
    assign start_tick = op_reg == spp_pkg::OP_TICK && playing_reg && count_reg != '0
                        && pass_dec <= 0 && count_reg != CW'(1);
    assign start_go = op_reg == spp_pkg::OP_START && !playing_reg && count_reg != '0;

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pinv_reg  <= 1'b0;
            pin_reg   <= '0;
            ratev_reg <= start_tick || start_go;
            stat_reg  <= spp_pkg::ST_OK;
            if (op_reg == spp_pkg::OP_COMMIT && full)
                stat_reg <= spp_pkg::ST_FULL;
            if (op_reg == spp_pkg::OP_TICK)
            begin
                if (playing_reg && count_reg != '0)
                begin
                    pinv_reg <= 1'b1;
                    pin_reg  <= {pat_rd_reg, 2'b00} & spp_pkg::PIN_MASK;
                end
                else
                    stat_reg <= spp_pkg::ST_IDLE;
            end
            if (op_reg == spp_pkg::OP_START && !start_go)
                stat_reg <= spp_pkg::ST_IDLE;
            rate_reg <= start_tick ? nxt_rd_reg[35:21] : hdr_rd_reg[35:21];
            if ((start_tick ? nxt_rd_reg[35:21] : hdr_rd_reg[35:21]) == '0)
                rate_reg <= 15'd1;
            sel_reg <= 3'd1;
            rem_reg <= '0;
            quo_reg <= '0;
            bit_reg <= 5'(DW - 1);
        end
        else if (cmd.div_step)
        begin
            // restoring division, MSB first
            logic [DW:0]   trial;
            logic [VW-1:0] dvs;
            logic [VW:0]   diff;
            trial = {rem_reg, spp_pkg::BASE_CLOCK[bit_reg]};
            dvs = VW'(rate_reg) << spp_pkg::pre_shift(sel_reg);
            diff = (VW+1)'(trial) - (VW+1)'(dvs);
            if (!diff[VW])
            begin
                rem_reg <= DW'(diff);
                quo_reg[bit_reg] <= 1'b1;
            end
            else
                rem_reg <= DW'(trial);
            bit_reg <= bit_reg - 1'b1;
            if (cmd.div_start)
            begin
                sel_reg <= sel_reg + 1'b1;
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 5'(DW - 1);
            end
        end
    end

    // quotient complete when bit 0 is done; q_fin forms the final value combinationally during that step
    logic [DW-1:0] q_fin;
    logic [DW-1:0] reg_val;
    always_comb
    begin
        q_fin = quo_reg;
        if ((VW+1)'({rem_reg, spp_pkg::BASE_CLOCK[0]}) >= (VW+1)'(VW'(rate_reg)
            << spp_pkg::pre_shift(sel_reg)))
            q_fin[0] = 1'b1;
        reg_val = q_fin - 1'b1;
    end

    assign sts.div_last = bit_reg == '0;
    assign sts.need_div = start_tick || start_go;
    assign sts.search_done = (reg_val <= DW'(spp_pkg::SEARCH_LIM) && q_fin != '0)
                             || sel_reg == 3'd5;

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && bit_reg == '0 && sts.search_done)
        begin
            compare_value <= (q_fin == '0 || reg_val > DW'(spp_pkg::COMPARE_CAP))
                             ? spp_pkg::COMPARE_CAP : 16'(reg_val);
            clock_select  <= sel_reg;
        end
        else if (cmd.exec)
        begin
            compare_value <= '0;
            clock_select  <= '0;
        end
    end

    assign pin_byte   = pin_reg;
    assign pin_valid  = pinv_reg;
    assign running    = playing_reg;
    assign rate_valid = ratev_reg;
    assign queued     = 6'(count_reg);
    assign status     = stat_reg;

endmodule

// ===== rtl/core/step_pattern_player_unit.sv =====
// ----------------------------------------------------------------------------
// step_pattern_player_unit: queued stepper pin pattern player
// Ring queue of motor messages, played one pattern per timer tick.
// ----------------------------------------------------------------------------
// Use: one item on in_ch (opcode plus message data) yields exactly one
// result on out_ch. Header, pattern and commit items fill the tail message;
// start begins playback of the head; each tick drives the next pattern.
// Items that start no message go through read, execute and result load. An
// item that starts a message (a start, or a tick that pops into a next
// message) also runs the prescaler search on a 21-step restoring divider,
// one quotient bit per step, trying up to 5 prescalers.
// Items are taken one at a time; in_ch.ready is high only between items.
// The result sits in an output register; a stalled receiver holds it and
// the next item still runs up to its result load, where it waits.
// Reset clears queue pointers, count, cursor, passes and the playing flag.
// Header and pattern stores hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module step_pattern_player_unit #(
    parameter int QUEUE_DEPTH  = 32,
    parameter int MAX_PATTERNS = 16
) (
    input logic clk,
    input logic rst_n,
    spp_in_if.sink    in_ch,
    spp_out_if.source out_ch
);

    spp_pkg::cmd_t cmd;
    spp_pkg::sts_t sts;
    logic          out_valid_reg;

    logic [7:0]  pin_byte;
    logic        pin_valid, running, rate_valid;
    logic [15:0] compare_value;
    logic [2:0]  clock_select;
    logic [5:0]  queued;
    logic [1:0]  status;

    spp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg && !out_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spp_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (in_ch.opcode),
        .rate_dekahertz (in_ch.rate_dekahertz),
        .repeat_count   (in_ch.repeat_count),
        .pattern_count  (in_ch.pattern_count),
        .pattern_index  (in_ch.pattern_index),
        .pattern_value  (in_ch.pattern_value),
        .pin_byte       (pin_byte),
        .pin_valid      (pin_valid),
        .running        (running),
        .rate_valid     (rate_valid),
        .compare_value  (compare_value),
        .clock_select   (clock_select),
        .queued         (queued),
        .status         (status)
    );

    // output register: payload frozen while a result waits
    logic [7:0]  pin_byte_reg;
    logic        pin_valid_reg, running_reg, rate_valid_reg;
    logic [15:0] cmp_reg;
    logic [2:0]  sel_reg;
    logic [5:0]  queued_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pin_byte_reg   <= pin_byte;
            pin_valid_reg  <= pin_valid;
            running_reg    <= running;
            rate_valid_reg <= rate_valid;
            cmp_reg        <= compare_value;
            sel_reg        <= clock_select;
            queued_reg     <= queued;
            status_reg     <= status;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pin_byte      = pin_byte_reg;
    assign out_ch.pin_valid     = pin_valid_reg;
    assign out_ch.running       = running_reg;
    assign out_ch.rate_valid    = rate_valid_reg;
    assign out_ch.compare_value = cmp_reg;
    assign out_ch.clock_select  = sel_reg;
    assign out_ch.queued        = queued_reg;
    assign out_ch.status        = status_reg;

    // a result load never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ch.ready))
        else $error("result overrun");

    // no new item while one is in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ch.ready)
        else $error("item accepted while busy");

    // queue count never exceeds depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(queued) <= QUEUE_DEPTH)
        else $error("queue count out of range");

    // pins only driven with low bits clear
    a_pins: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_ch.pin_byte[1:0] == 2'b00)
        else $error("pin low bits set");

endmodule
